@@ hdl/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and helpers for the byte ring fifo with peek.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_WRONG = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [8:0] position;
  } brf_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] peek_data;
    logic [8:0] fill_level;
    logic       is_full;
    logic       is_empty;
  } brf_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } brf_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } brf_state_t;

  // clamp configured length to 1..DEPTH
  function automatic logic [CNT_W-1:0] eff_len(input logic [8:0] len);
    logic [CNT_W-1:0] l;
    begin
      if (len == 9'd0) begin
        l = CNT_W'(1);
      end else if ({23'd0, len} > DEPTH) begin
        l = CNT_W'(DEPTH);
      end else begin
        l = CNT_W'(len);
      end
      return l;
    end
  endfunction

  // next slot, wrapping at the effective length
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] n;
    begin
      n = {1'b0, idx} + CNT_W'(1);
      return (n >= len) ? '0 : n[IDX_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/brf_ctrl.sv @@
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer: takes one operation, lets the datapath execute it, then holds
// the result until the output transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output brf_pkg::brf_cmd_t     cmd
);

  brf_pkg::brf_state_t state_r;
  brf_pkg::brf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      brf_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = brf_pkg::S_EXEC;
        end
      end
      brf_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = brf_pkg::S_OUT;
      end
      brf_pkg::S_OUT: begin
        out_valid   = 1'b1;
        in_stall    = out_stall;
        cmd.capture = in_valid && !out_stall;
        if (!out_stall) begin
          state_nxt = in_valid ? brf_pkg::S_EXEC : brf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = brf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/brf_dp.sv @@
// ----------------------------------------------------------------------------
// brf_dp
// Datapath: ring storage, head/tail/count registers, length register and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire brf_pkg::brf_cmd_t cmd,
  input  wire brf_pkg::brf_in_t  in_item,
  input  wire logic              cfg_wr_en,
  input  wire logic [8:0]        cfg_wr_data,
  output brf_pkg::brf_out_t      out_item
);

  logic [7:0]                  mem_r [brf_pkg::DEPTH];
  logic [7:0]                  rdata_r;

  brf_pkg::brf_in_t            op_r;
  logic [brf_pkg::IDX_W-1:0]   head_r, head_nxt;
  logic [brf_pkg::IDX_W-1:0]   tail_r, tail_nxt;
  logic [brf_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [8:0]                  len_r;
  logic [1:0]                  status_r, status_nxt;
  logic                        peek_ok_r, peek_ok_nxt;

  logic [brf_pkg::CNT_W-1:0]   eff;
  logic                        wr_en;
  logic                        rd_en;
  logic [brf_pkg::IDX_W-1:0]   rd_addr;
  logic [brf_pkg::IDX_W-1:0]   head_adv;
  logic [8:0]                  pos_m1;
  logic [brf_pkg::CNT_W:0]     peek_sum;
  logic [brf_pkg::CNT_W:0]     peek_wrap;

  assign eff       = brf_pkg::eff_len(len_r);
  assign head_adv  = brf_pkg::advance(head_r, eff);
  assign pos_m1    = op_r.position - 9'd1;
  assign peek_sum  = {2'b00, head_adv} + {1'b0, pos_m1};
  assign peek_wrap = (peek_sum >= {1'b0, eff}) ? (peek_sum - {1'b0, eff}) : peek_sum;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    peek_ok_nxt = peek_ok_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_r;
    if (cmd.exec) begin
      status_nxt  = brf_pkg::ST_OK;
      peek_ok_nxt = 1'b0;
      unique case (op_r.kind)
        brf_pkg::KIND_PUSH: begin
          if (count_r >= eff) begin
            status_nxt = brf_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            tail_nxt  = brf_pkg::advance(tail_r, eff);
            count_nxt = count_r + brf_pkg::CNT_W'(1);
          end
        end
        brf_pkg::KIND_POP: begin
          if (count_r == '0) begin
            status_nxt = brf_pkg::ST_EMPTY;
          end else begin
            head_nxt  = head_adv;
            count_nxt = count_r - brf_pkg::CNT_W'(1);
          end
        end
        brf_pkg::KIND_PEEK: begin
          if (op_r.position > eff) begin
            status_nxt = brf_pkg::ST_WRONG;
          end else if (op_r.position >= count_r) begin
            status_nxt = brf_pkg::ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            peek_ok_nxt = 1'b1;
            rd_addr     = (op_r.position == 9'd0) ? head_r
                                                   : peek_wrap[brf_pkg::IDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      len_r   <= 9'(brf_pkg::DEPTH);
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_item;
    end
    status_r  <= status_nxt;
    peek_ok_r <= peek_ok_nxt;
  end

  // ring storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[tail_r] <= op_r.data_byte;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    out_item.status     = status_r;
    out_item.peek_data  = peek_ok_r ? rdata_r : 8'd0;
    out_item.fill_level = count_r;
    out_item.is_full    = (count_r >= eff);
    out_item.is_empty   = (count_r == '0);
  end

endmodule

`default_nettype wire

@@ hdl/byte_ring_fifo_with_peek.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek
// Byte ring buffer of configurable length with push, pop and peek.
// Flow: an accepted operation is captured, run in the execute step with the
// registered ring read, and its result is held valid until it transfers;
// a new operation is taken in the cycle its predecessor's result transfers,
// so operations do not overlap.
// Reset: synchronous, active low; empties the ring and sets length to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_peek (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire brf_pkg::brf_in_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output brf_pkg::brf_out_t      out_item,
  input  wire logic              cfg_wr_en,
  input  wire logic [8:0]        cfg_wr_data
);

  brf_pkg::brf_cmd_t cmd;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  brf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire
